### src/fsa_pkg.sv
// Shared types and constants for the sector allocation table block.
// No dependencies; every other file of the block but fsa_ram imports this package.
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int unsigned ENTRY_W  = 12;
  localparam int unsigned SECTOR_W = 11;
  localparam int unsigned OP_W     = 3;
  // Wide enough to compare any sector, counter or table size up to 4096.
  localparam int unsigned CMP_W    = 13;

  localparam int unsigned TABLE_ENTRIES_DEF = 2048;

  localparam logic [CMP_W-1:0]    SYSTEM_SECTORS = 13'd14;
  localparam logic [ENTRY_W-1:0]  RESERVED_MARK  = 12'hDDD;
  localparam logic [SECTOR_W-1:0] TOTAL_RESET    = 11'd1440;

  // Configuration port: byte address width and word index of each register.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TOTAL_SECTORS = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_FORMAT = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_FIND   = 3'd3,
    OP_LINK   = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;
    logic [ENTRY_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]  entry_value;
    logic [SECTOR_W-1:0] found_sector;
    logic                table_full;
  } res_t;

endpackage

### src/fsa_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fsa_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/fsa_cfg.sv
// Configuration register file: holds the disk sector count behind an APB-style port.
// Depends on fsa_pkg.
`timescale 1ns / 1ps

module fsa_cfg import fsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o,
  output logic [SECTOR_W-1:0]   total_sectors_o
);

  logic [SECTOR_W-1:0] total_q, total_d;
  logic                sel_total;

  assign sel_total = (paddr_i[APB_ADDR_W-1:2] == REG_TOTAL_SECTORS);
  assign pready_o  = 1'b1;

  always_comb begin
    total_d = total_q;
    if (psel_i && penable_i && pwrite_i && sel_total) begin
      total_d = pwdata_i[SECTOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else begin
      total_q <= total_d;
    end
  end

  assign prdata_o        = sel_total ? APB_DATA_W'(total_q) : '0;
  assign total_sectors_o = total_q;

endmodule

### src/fsa_seq.sv
// Sequencer that walks the entry memory for clear, format and free search,
// and serves single reads, writes and links. Depends on fsa_pkg and fsa_ram.
`timescale 1ns / 1ps

module fsa_seq import fsa_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SECTOR_W-1:0] total_sectors_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cmd_t                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                res_o
);

  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0]    LastIdx  = CW'(TableEntries - 1);
  localparam logic [CMP_W-1:0] TableCmp = CMP_W'(TableEntries);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_FORMAT  = 7'b0000100,
    ST_RD_WAIT = 7'b0001000,
    ST_SEARCH  = 7'b0010000,
    ST_LINK_WR = 7'b0100000,
    ST_RESP    = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pvld_q, pvld_d;
  logic [AW-1:0]  pidx_q, pidx_d;
  cmd_t           cmd_q, cmd_d;
  res_t           res_q, res_d;
  res_t           out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [CMP_W-1:0] sect_in_ext, sect_q_ext, total_ext, limit, cnt_ext, pidx_ext;
  logic             in_table_in, in_table_q, hit;

  fsa_ram #(
    .Width (ENTRY_W),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign sect_in_ext = CMP_W'(cmd_i.sector);
  assign sect_q_ext  = CMP_W'(cmd_q.sector);
  assign in_table_in = sect_in_ext < TableCmp;
  assign in_table_q  = sect_q_ext < TableCmp;
  assign total_ext   = CMP_W'(total_sectors_i);
  assign limit       = (total_ext > TableCmp) ? TableCmp : total_ext;
  assign cnt_ext     = CMP_W'(cnt_q);
  assign pidx_ext    = CMP_W'(pidx_q);

  // The entry read last cycle belongs to pidx_q; it is a hit when free and not excluded.
  assign hit = pvld_q && (ram_rdata == '0) && (pidx_ext != sect_q_ext);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pvld_d      = 1'b0;
    pidx_d      = pidx_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = cnt_q[AW-1:0];
    ram_wdata   = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          res_d = '0;
          case (op_e'(cmd_i.op))
            OP_FORMAT: begin
              cnt_d   = '0;
              state_d = ST_FORMAT;
            end
            OP_READ: begin
              ram_addr = sect_in_ext[AW-1:0];
              state_d  = ST_RD_WAIT;
            end
            OP_WRITE: begin
              ram_we    = in_table_in;
              ram_addr  = sect_in_ext[AW-1:0];
              ram_wdata = cmd_i.value;
              state_d   = ST_RESP;
            end
            OP_FIND, OP_LINK: begin
              cnt_d   = CW'(1);
              state_d = ST_SEARCH;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_FORMAT: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt_ext < SYSTEM_SECTORS || cnt_ext >= total_ext) ? RESERVED_MARK : '0;
        if (cnt_q == LastIdx) begin
          state_d = ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_RD_WAIT: begin
        res_d.entry_value = in_table_q ? ram_rdata : '0;
        state_d           = ST_RESP;
      end

      ST_SEARCH: begin
        if (hit) begin
          res_d.found_sector = pidx_ext[SECTOR_W-1:0];
          if (op_e'(cmd_q.op) == OP_LINK && in_table_q) begin
            state_d = ST_LINK_WR;
          end else begin
            state_d = ST_RESP;
          end
        end else if (cnt_ext < limit) begin
          ram_addr = cnt_q[AW-1:0];
          pvld_d   = 1'b1;
          pidx_d   = cnt_q[AW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else if (!pvld_q) begin
          res_d.table_full = 1'b1;
          state_d          = ST_RESP;
        end
      end

      ST_LINK_WR: begin
        ram_we    = 1'b1;
        ram_addr  = sect_q_ext[AW-1:0];
        ram_wdata = ENTRY_W'(res_q.found_sector);
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pvld_q      <= pvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // A new result beat only ever comes out of the response state.
  a_out_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_RESP))
    else $error("result beat raised outside the response state");

  // A full table never comes with a found sector.
  a_full_no_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.table_full) |-> (out_q.found_sector == '0))
    else $error("table_full set together with a found sector");

  // A read result and a search result never share one beat.
  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.entry_value != '0 && out_q.found_sector != '0))
    else $error("entry value and found sector both nonzero");

  // The free search only reads the table.
  a_search_ro : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !ram_we)
    else $error("table written during free search");

  // A link write stores a found sector, never zero.
  a_link_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK_WR) |-> (ram_wdata != '0))
    else $error("link stores an empty successor");

endmodule

### src/fat12_sector_allocator.sv
// Top level of the sector allocation table: stream command and result channels
// plus an APB-style configuration port. Depends on fsa_pkg, fsa_cfg and fsa_seq.
//
// Usage: each command beat on the slave stream carries an operation in tuser
// (format, read entry, write entry, find free, link next) and a sector and
// entry value in tdata. Every command gives exactly one result beat on the
// master stream: the entry read, the free sector found, and a full flag.
// Commands are handled one at a time; s_axis_tready is high only while the
// sequencer waits for a command.
// Format and free search walk the entry memory one entry per cycle. A search scans
// up from sector 1 to the first free sector other than its own, and flags a full
// table if none below limit = min(total_sectors, TABLE_ENTRIES) is free; a link
// that finds one writes it into its own sector's entry when that is in the table.
// After reset the block clears all TABLE_ENTRIES entries, one per cycle, before it
// raises s_axis_tready; configuration writes are taken during that pass.
// The result sits in an output register; while the receiver stalls, the next
// command is still taken and processed, and its result waits until the held
// beat has been taken.
`timescale 1ns / 1ps

module fat12_sector_allocator import fsa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis_tdata: sector [10:0], value [22:11], zero [23]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,
  // s_axis_tuser: op [2:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  // m_axis_tdata: entry_value [11:0], found_sector [22:12], zero [23]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,
  // m_axis_tuser: table_full [0]
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SECTOR_W-1:0] total_sectors;
  cmd_t                cmd;
  res_t                res;

  assign cmd.op     = s_axis_tuser;
  assign cmd.sector = s_axis_tdata[SECTOR_W-1:0];
  assign cmd.value  = s_axis_tdata[SECTOR_W+ENTRY_W-1:SECTOR_W];

  fsa_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready),
    .total_sectors_o (total_sectors)
  );

  fsa_seq #(
    .TableEntries (TABLE_ENTRIES)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .total_sectors_i (total_sectors),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .cmd_i           (cmd),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .res_o           (res)
  );

  assign m_axis_tdata = {1'b0, res.found_sector, res.entry_value};
  assign m_axis_tuser = res.table_full;

endmodule

### tb/sv/tb_fat12_sector_allocator.sv
// Self-checking testbench for fat12_sector_allocator: directed table, then random
// commands under three idle patterns, checked against a behavioral table model.
// Depends on fsa_pkg and the fat12_sector_allocator RTL.
`timescale 1ns / 1ps

module tb_fat12_sector_allocator;
  import fsa_pkg::*;

  localparam int unsigned TBL_N    = TABLE_ENTRIES_DEF;
  localparam int unsigned DISK_MIN = 15;
  localparam int unsigned DISK_MAX = 1705;

  // Opcodes the block does not define; they must leave the table alone.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CHECKED,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector;
    logic [ENTRY_W-1:0]  value;
    res_t                want;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Behavioral copy of the allocation table and its sector count.
  logic [ENTRY_W-1:0]  fat_table [TBL_N];
  logic [SECTOR_W-1:0] disk_sectors;
  res_t                fat_replies [$];
  step_row_t           dir_rows [$];

  int err_count     = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 62;
  int cmds_sent     = 0;
  int formats_sent  = 0;
  int searches_hit  = 0;
  int searches_full = 0;
  int cfg_writes    = 0;

  fat12_sector_allocator DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("fat12_sector_allocator regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Lowest free sector from 1 up, below min(disk_sectors, TBL_N), other than skip.
  function automatic logic [SECTOR_W-1:0] first_free(input logic [SECTOR_W-1:0] skip,
                                                     output logic none);
    int unsigned lim;
    lim = (disk_sectors > TBL_N) ? TBL_N : disk_sectors;
    none = 1'b1;
    first_free = '0;
    for (int unsigned s = 1; s < lim; s++) begin
      if (none && fat_table[s] == '0 && s != skip) begin
        none = 1'b0;
        first_free = SECTOR_W'(s);
      end
    end
  endfunction

  // Applies one command to the table copy and returns the reply it gives.
  function automatic res_t fat_apply(input logic [OP_W-1:0] op,
                                     input logic [SECTOR_W-1:0] sec,
                                     input logic [ENTRY_W-1:0] val);
    res_t r;
    logic none;
    r = '0;
    case (op)
      OP_FORMAT: begin
        for (int unsigned i = 0; i < TBL_N; i++)
          fat_table[i] = (i < SYSTEM_SECTORS || i >= disk_sectors) ? RESERVED_MARK : '0;
      end
      OP_READ: begin
        if (sec < TBL_N) r.entry_value = fat_table[sec];
      end
      OP_WRITE: begin
        if (sec < TBL_N) fat_table[sec] = val;
      end
      OP_FIND: begin
        r.found_sector = first_free(sec, none);
        r.table_full   = none;
      end
      OP_LINK: begin
        r.found_sector = first_free(sec, none);
        r.table_full   = none;
        if (!none && sec < TBL_N) fat_table[sec] = ENTRY_W'(r.found_sector);
      end
      default: ;
    endcase
    return r;
  endfunction

  // The caller either issues a command or lowers tvalid in the step in which the
  // previous beat was taken, so tvalid never gets two assignments in one step.
  task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [SECTOR_W-1:0] sec,
                           input logic [ENTRY_W-1:0] val, input bit known, input res_t want);
    res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, sec};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = fat_apply(op, sec, val);
    fat_replies.push_back(known ? want : r);
    cmds_sent++;
    if (op == OP_FORMAT) formats_sent++;
    if (op == OP_FIND || op == OP_LINK) begin
      if (r.table_full) searches_full++;
      else searches_hit++;
    end
  endtask

  task automatic quiesce_stream();
    s_axis_tvalid <= 1'b0;
    while (fat_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_disk_sectors(input int unsigned n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TOTAL_SECTORS, 2'b00};
    pwdata  <= APB_DATA_W'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    disk_sectors = SECTOR_W'(n);
    cfg_writes++;
  endtask

  function automatic void add_row(input row_kind_e kind, input logic [OP_W-1:0] op,
                                  input int unsigned sec, input int unsigned val,
                                  input int unsigned ev, input int unsigned fs,
                                  input bit full);
    step_row_t row;
    row.kind              = kind;
    row.op                = op;
    row.sector            = SECTOR_W'(sec);
    row.value             = ENTRY_W'(val);
    row.want.entry_value  = ENTRY_W'(ev);
    row.want.found_sector = SECTOR_W'(fs);
    row.want.table_full   = full;
    dir_rows.push_back(row);
  endfunction

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fat_replies.size() == 0) begin
        report_mismatch($sformatf("result beat with no command pending, tdata %h",
                                  m_axis_tdata));
      end else begin
        want = fat_replies.pop_front();
        if (m_axis_tdata[11:0] !== want.entry_value)
          report_mismatch($sformatf("entry_value %h, expected %h",
                                    m_axis_tdata[11:0], want.entry_value));
        if (m_axis_tdata[22:12] !== want.found_sector)
          report_mismatch($sformatf("found_sector %0d, expected %0d",
                                    m_axis_tdata[22:12], want.found_sector));
        if (m_axis_tuser !== want.table_full)
          report_mismatch($sformatf("table_full %b, expected %b",
                                    m_axis_tuser, want.table_full));
      end
    end
  end

  initial begin
    step_row_t   row;
    int unsigned n;
    int unsigned hi;
    int unsigned pick;
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sec;
    logic [ENTRY_W-1:0]  val;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (int unsigned i = 0; i < TBL_N; i++) fat_table[i] = '0;
    disk_sectors = TOTAL_RESET;

    // Fresh table: everything free, sector count 1440.
    add_row(ROW_KNOWN,   OP_READ,    0,    0,     0,      0,  1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    0,    0,     0,      1,  1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    1,    0,     0,      2,  1'b0);
    // Format reserves the system sectors and everything past the disk end.
    add_row(ROW_KNOWN,   OP_FORMAT,  0,    0,     0,      0,  1'b0);
    add_row(ROW_KNOWN,   OP_READ,    13,   0,     12'hDDD, 0, 1'b0);
    add_row(ROW_KNOWN,   OP_READ,    14,   0,     0,      0,  1'b0);
    add_row(ROW_KNOWN,   OP_READ,    1440, 0,     12'hDDD, 0, 1'b0);
    add_row(ROW_KNOWN,   OP_READ,    2047, 0,     12'hDDD, 0, 1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    0,    0,     0,      14, 1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    14,   0,     0,      15, 1'b0);
    add_row(ROW_KNOWN,   OP_WRITE,   2047, 12'hFFF, 0,    0,  1'b0);
    add_row(ROW_KNOWN,   OP_READ,    2047, 0,     12'hFFF, 0, 1'b0);
    add_row(ROW_CHECKED, OP_WRITE,   0,    12'hA5A, 0,    0,  1'b0);
    add_row(ROW_KNOWN,   OP_LINK,    14,   0,     0,      15, 1'b0);
    add_row(ROW_KNOWN,   OP_READ,    14,   0,     12'h00F, 0, 1'b0);
    add_row(ROW_KNOWN,   OP_SPARE_5, 2047, 12'hFFF, 0,    0,  1'b0);
    add_row(ROW_KNOWN,   OP_SPARE_6, 14,   12'h555, 0,    0,  1'b0);
    add_row(ROW_KNOWN,   OP_SPARE_7, 0,    12'hAAA, 0,    0,  1'b0);
    // Smallest disk: sector 14 is the only one that can be free.
    add_row(ROW_CFG,     OP_FORMAT,  0,    DISK_MIN, 0,   0,  1'b0);
    add_row(ROW_KNOWN,   OP_FORMAT,  0,    0,     0,      0,  1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    14,   0,     0,      0,  1'b1);
    add_row(ROW_KNOWN,   OP_LINK,    14,   0,     0,      0,  1'b1);
    add_row(ROW_KNOWN,   OP_LINK,    3,    0,     0,      14, 1'b0);
    add_row(ROW_KNOWN,   OP_READ,    3,    0,     12'h00E, 0, 1'b0);
    add_row(ROW_KNOWN,   OP_WRITE,   14,   12'hFFF, 0,    0,  1'b0);
    add_row(ROW_KNOWN,   OP_FIND,    0,    0,     0,      0,  1'b1);
    // Largest disk.
    add_row(ROW_CFG,     OP_FORMAT,  0,    DISK_MAX, 0,   0,  1'b0);
    add_row(ROW_KNOWN,   OP_FORMAT,  0,    0,     0,      0,  1'b0);
    add_row(ROW_KNOWN,   OP_READ,    1705, 0,     12'hDDD, 0, 1'b0);
    add_row(ROW_CHECKED, OP_LINK,    1704, 0,     0,      0,  1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        quiesce_stream();
        set_disk_sectors(row.value);
      end else begin
        issue_cmd(row.op, row.sector, row.value, row.kind == ROW_KNOWN, row.want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 16 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        // Small disks fill up quickly, which is where the full-table paths live.
        if (blk == 0) n = (phase == 1) ? DISK_MAX : DISK_MIN;
        else if (phase == 2 && blk == 3) n = TOTAL_RESET;
        else if ($urandom_range(0, 4) == 0) n = $urandom_range(DISK_MIN, DISK_MAX);
        else n = $urandom_range(DISK_MIN, 24);
        quiesce_stream();
        set_disk_sectors(n);
        if ($urandom_range(0, 3) != 0) issue_cmd(OP_FORMAT, '0, '0, 1'b0, '0);
        for (int k = 0; k < 21; k++) begin
          if ($urandom_range(0, 15) == 0) quiesce_stream();
          hi = (n + 1 > 2047) ? 2047 : n + 1;
          if ($urandom_range(0, 3) == 0) sec = SECTOR_W'($urandom_range(0, 2047));
          else sec = SECTOR_W'($urandom_range(0, hi));
          case ($urandom_range(0, 5))
            0:       val = '0;
            1:       val = 12'hFFF;
            2:       val = ENTRY_W'($urandom_range(1, n));
            default: val = ENTRY_W'($urandom_range(0, 4095));
          endcase
          pick = $urandom_range(0, 99);
          if (pick < 3) op = OP_FORMAT;
          else if (pick < 23) op = OP_READ;
          else if (pick < 53) op = OP_WRITE;
          else if (pick < 71) op = OP_FIND;
          else if (pick < 91) op = OP_LINK;
          else begin
            case ($urandom_range(0, 2))
              0:       op = OP_SPARE_5;
              1:       op = OP_SPARE_6;
              default: op = OP_SPARE_7;
            endcase
          end
          issue_cmd(op, sec, val, 1'b0, '0);
        end
      end
    end

    quiesce_stream();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands (%0d formats) across %0d sector-count writes.",
             cmds_sent, formats_sent, cfg_writes);
    $display("Searches: %0d found a free sector, %0d found the table full.",
             searches_hit, searches_full);
    if (err_count == 0 && fat_replies.size() == 0) begin
      $display("fat12_sector_allocator regression: pass");
    end else begin
      $display("fat12_sector_allocator regression: fail");
    end
    $finish;
  end

endmodule
